// ===== rtl/core/rstmg_pkg.sv =====
`default_nettype none
package rstmg_pkg;

	localparam int SIDE_MAX   = 16;
	localparam int WALL_DEPTH = 480;

	localparam int SIDE_W = 5;   // side_size register
	localparam int CRD_W  = 4;   // row / column
	localparam int ZONE_W = 8;   // zone label
	localparam int IDX_W  = 9;   // table index
	localparam int CNT_W  = 9;   // wall / zone counts
	localparam int EPTR_W = 10;  // emit pointer
	localparam int RND_W  = 16;
	localparam int BRD_W  = 6;   // border wall counter

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_NEXT  = 2'd2;

	localparam logic REG_SIDE   = 1'b0;
	localparam logic REG_BORDER = 1'b1;

	typedef struct packed {
		logic [ZONE_W-1:0] zone_a;
		logic [ZONE_W-1:0] zone_b;
		logic [CRD_W-1:0]  col;
		logic [CRD_W-1:0]  row;
		logic              below;
	} wall_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FILL,
		ST_DIV,
		ST_PICK,
		ST_PICKW,
		ST_SHIFT,
		ST_DRAWEND,
		ST_NRD,
		ST_NWAIT,
		ST_BORDER,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start_init;
		logic fill_step;
		logic div_step;
		logic pick_rd;
		logic pick_cap;
		logic shift_step;
		logic draw_end;
		logic next_rd;
		logic next_cap;
		logic border_init;
		logic border_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       fill_done;
		logic       div_last;
		logic       draw_ok;
		logic       shift_done;
		logic       next_ok;
		logic       next_tab;
		logic       border_hit;
		logic       out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/rstmg_ctrl.sv =====
`default_nettype none
module rstmg_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_accept,
	input  wire rstmg_pkg::sts_t sts,
	output rstmg_pkg::cmd_t      cmd,
	output logic                 busy
);

	rstmg_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rstmg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rstmg_pkg::ST_IDLE: begin
				if (in_accept) state_d = rstmg_pkg::ST_DECODE;
			end
			rstmg_pkg::ST_DECODE: begin
				priority if (sts.op == rstmg_pkg::OP_START) state_d = rstmg_pkg::ST_FILL;
				else if (sts.op == rstmg_pkg::OP_DRAW)
					state_d = sts.draw_ok ? rstmg_pkg::ST_DIV : rstmg_pkg::ST_DONE;
				else if (sts.op == rstmg_pkg::OP_NEXT) begin
					priority if (!sts.next_ok) state_d = rstmg_pkg::ST_DONE;
					else if (sts.next_tab) state_d = rstmg_pkg::ST_NRD;
					else state_d = rstmg_pkg::ST_BORDER;
				end else state_d = rstmg_pkg::ST_DONE;
			end
			rstmg_pkg::ST_FILL:    if (sts.fill_done) state_d = rstmg_pkg::ST_DONE;
			rstmg_pkg::ST_DIV:     if (sts.div_last) state_d = rstmg_pkg::ST_PICK;
			rstmg_pkg::ST_PICK:    state_d = rstmg_pkg::ST_PICKW;
			rstmg_pkg::ST_PICKW:   state_d = rstmg_pkg::ST_SHIFT;
			rstmg_pkg::ST_SHIFT:   if (sts.shift_done) state_d = rstmg_pkg::ST_DRAWEND;
			rstmg_pkg::ST_DRAWEND: state_d = rstmg_pkg::ST_DONE;
			rstmg_pkg::ST_NRD:     state_d = rstmg_pkg::ST_NWAIT;
			rstmg_pkg::ST_NWAIT:   state_d = rstmg_pkg::ST_DONE;
			rstmg_pkg::ST_BORDER:  if (sts.border_hit) state_d = rstmg_pkg::ST_DONE;
			rstmg_pkg::ST_DONE:    if (sts.out_free) state_d = rstmg_pkg::ST_IDLE;
			default:               state_d = rstmg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != rstmg_pkg::ST_IDLE);
		unique case (state_q)
			rstmg_pkg::ST_DECODE: begin
				cmd.start_init  = (sts.op == rstmg_pkg::OP_START);
				cmd.border_init = 1'b1;
			end
			rstmg_pkg::ST_FILL:    cmd.fill_step   = 1'b1;
			rstmg_pkg::ST_DIV:     cmd.div_step    = 1'b1;
			rstmg_pkg::ST_PICK:    cmd.pick_rd     = 1'b1;
			rstmg_pkg::ST_PICKW:   cmd.pick_cap    = 1'b1;
			rstmg_pkg::ST_SHIFT:   cmd.shift_step  = 1'b1;
			rstmg_pkg::ST_DRAWEND: cmd.draw_end    = 1'b1;
			rstmg_pkg::ST_NRD:     cmd.next_rd     = 1'b1;
			rstmg_pkg::ST_NWAIT:   cmd.next_cap    = 1'b1;
			rstmg_pkg::ST_BORDER:  cmd.border_step = 1'b1;
			rstmg_pkg::ST_DONE:    cmd.out_load    = sts.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/rstmg_datapath.sv =====
`default_nettype none
module rstmg_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [rstmg_pkg::SIDE_W-1:0] cfg_wdata,
	input  wire logic                         in_accept,
	input  wire logic [1:0]                   operation,
	input  wire logic [rstmg_pkg::RND_W-1:0]  random_value,
	input  wire logic [rstmg_pkg::CRD_W-1:0]  hole_col,
	input  wire logic [rstmg_pkg::CRD_W-1:0]  hole_row,
	input  wire rstmg_pkg::cmd_t              cmd,
	output rstmg_pkg::sts_t                   sts,
	input  wire logic                         out_stall,
	output logic                              out_valid,
	output logic                              wall_valid,
	output logic [rstmg_pkg::CRD_W-1:0]       wall_col,
	output logic [rstmg_pkg::CRD_W-1:0]       wall_row,
	output logic                              wall_below,
	output logic                              connected,
	output logic                              final_last
);

	localparam int SW = rstmg_pkg::SIDE_W;
	localparam int CW = rstmg_pkg::CRD_W;
	localparam int ZW = rstmg_pkg::ZONE_W;
	localparam int IW = rstmg_pkg::IDX_W;
	localparam int NW = rstmg_pkg::CNT_W;
	localparam int EW = rstmg_pkg::EPTR_W;
	localparam int RW = rstmg_pkg::RND_W;
	localparam int BW = rstmg_pkg::BRD_W;

	// config and run state
	logic [SW-1:0] side_q, grid_q;
	logic [1:0]    bmode_q;
	logic [NW-1:0] wcnt_q, zcnt_q;
	logic [EW-1:0] eptr_q;
	logic [7:0]    holes_q, hin_q;
	logic [1:0]    op_q;
	logic [RW-1:0] rnd_q;
	logic [IW-1:0] rem_q;
	logic [3:0]    dcnt_q;
	logic [CW-1:0] fx_q, fy_q;
	logic          fsub_q;
	logic [ZW-1:0] cell_q;
	rstmg_pkg::wall_t pick_q;
	logic [IW-1:0] ri_q, wa_s1;
	logic          wr_s1;
	logic [CW-1:0] ba_q;
	logic [BW-1:0] bn_q;
	logic          rv_q, rbel_q, rlast_q;
	logic [CW-1:0] rcol_q, rrow_q;

	rstmg_pkg::wall_t mem_q [rstmg_pkg::WALL_DEPTH];
	rstmg_pkg::wall_t rd_q;

	// combinational helpers
	logic [SW-1:0]  s_cl;
	logic [CW-1:0]  gm1, hc, hr;
	logic [SW-1:0]  nr, nbt;
	logic [BW-1:0]  nb, k;
	logic [EW-1:0]  total, eptr_inc;
	logic           last_nx;
	logic [IW:0]    dtry;
	logic           fill_we, shift_more, zdiff, rp, bp, hit_r, hit_b;
	logic [IW-1:0]  src, raddr, waddr;
	logic           we;
	rstmg_pkg::wall_t wdata, fill_w, relab;

	always_comb begin
		priority if (side_q < SW'(2)) s_cl = SW'(2);
		else if (side_q > SW'(rstmg_pkg::SIDE_MAX)) s_cl = SW'(rstmg_pkg::SIDE_MAX);
		else s_cl = side_q;
	end

	assign gm1 = CW'(grid_q - SW'(1));
	assign hc  = holes_q[3:0];
	assign hr  = holes_q[7:4];
	assign nr  = bmode_q[0] ? (grid_q - SW'({4'd0, SW'(hc) < grid_q})) : '0;
	assign nbt = bmode_q[1] ? (grid_q - SW'({4'd0, SW'(hr) < grid_q})) : '0;
	assign nb  = BW'(nr) + BW'(nbt);
	assign total    = EW'(wcnt_q) + EW'(nb);
	assign eptr_inc = eptr_q + EW'(1);
	assign last_nx  = (eptr_inc == total);
	assign k        = BW'(eptr_q - EW'(wcnt_q));

	// restoring remainder step
	assign dtry = {rem_q, rnd_q[RW-1]};

	// fill entry
	assign fill_we = cmd.fill_step && (fsub_q ? (fy_q != gm1) : (fx_q != gm1));
	always_comb begin
		fill_w.zone_a = cell_q;
		fill_w.zone_b = fsub_q ? (cell_q + ZW'(grid_q)) : (cell_q + ZW'(1));
		fill_w.col    = fx_q;
		fill_w.row    = fy_q;
		fill_w.below  = fsub_q;
	end

	// shift with zone relabel
	assign zdiff      = (pick_q.zone_a != pick_q.zone_b);
	assign shift_more = (ri_q < (wcnt_q - NW'(1)));
	assign src        = (ri_q < rem_q) ? ri_q : (ri_q + IW'(1));
	always_comb begin
		relab = rd_q;
		if (zdiff && rd_q.zone_a == pick_q.zone_b) relab.zone_a = pick_q.zone_a;
		if (zdiff && rd_q.zone_b == pick_q.zone_b) relab.zone_b = pick_q.zone_a;
	end

	always_comb begin
		priority if (cmd.pick_rd) raddr = rem_q;
		else if (cmd.shift_step) raddr = src;
		else raddr = eptr_q[IW-1:0];
	end

	assign we    = fill_we || wr_s1;
	assign waddr = wr_s1 ? wa_s1 : IW'(wcnt_q);
	assign wdata = wr_s1 ? relab : fill_w;

	// border walk
	assign rp    = bmode_q[0] && (ba_q != hc);
	assign bp    = bmode_q[1] && (ba_q != hr);
	assign hit_r = rp && (bn_q == k);
	assign hit_b = bp && ((bn_q + BW'(rp)) == k);

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rd_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q  <= SW'(8);
			bmode_q <= '0;
			grid_q  <= SW'(2);
			wcnt_q  <= '0;
			zcnt_q  <= '0;
			eptr_q  <= '0;
			holes_q <= '0;
			hin_q   <= '0;
			op_q    <= '0;
			rnd_q   <= '0;
			rem_q   <= '0;
			dcnt_q  <= '0;
			fx_q    <= '0;
			fy_q    <= '0;
			fsub_q  <= 1'b0;
			cell_q  <= '0;
			pick_q  <= '0;
			ri_q    <= '0;
			wa_s1   <= '0;
			wr_s1   <= 1'b0;
			ba_q    <= '0;
			bn_q    <= '0;
			rv_q    <= 1'b0;
			rcol_q  <= '0;
			rrow_q  <= '0;
			rbel_q  <= 1'b0;
			rlast_q <= 1'b0;
			out_valid  <= 1'b0;
			wall_valid <= 1'b0;
			wall_col   <= '0;
			wall_row   <= '0;
			wall_below <= 1'b0;
			connected  <= 1'b0;
			final_last <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					rstmg_pkg::REG_SIDE:   side_q  <= cfg_wdata;
					rstmg_pkg::REG_BORDER: bmode_q <= cfg_wdata[1:0];
					default: ;
				endcase
			end
			if (in_accept) begin
				op_q    <= operation;
				rnd_q   <= random_value;
				hin_q   <= {hole_row, hole_col};
				rem_q   <= '0;
				dcnt_q  <= '0;
				rv_q    <= 1'b0;
				rcol_q  <= '0;
				rrow_q  <= '0;
				rbel_q  <= 1'b0;
				rlast_q <= 1'b0;
			end
			if (cmd.start_init) begin
				grid_q  <= s_cl;
				wcnt_q  <= '0;
				zcnt_q  <= NW'(s_cl) * NW'(s_cl);
				eptr_q  <= '0;
				holes_q <= hin_q;
				fx_q    <= '0;
				fy_q    <= '0;
				fsub_q  <= 1'b0;
				cell_q  <= '0;
			end
			if (cmd.fill_step) begin
				if (fill_we) wcnt_q <= wcnt_q + NW'(1);
				fsub_q <= ~fsub_q;
				if (fsub_q) begin
					cell_q <= cell_q + ZW'(1);
					if (fx_q == gm1) begin
						fx_q <= '0;
						fy_q <= fy_q + CW'(1);
					end else begin
						fx_q <= fx_q + CW'(1);
					end
				end
			end
			if (cmd.div_step) begin
				rnd_q  <= {rnd_q[RW-2:0], 1'b0};
				dcnt_q <= dcnt_q + 4'd1;
				rem_q  <= (dtry >= (IW+1)'(wcnt_q)) ? IW'(dtry - (IW+1)'(wcnt_q)) : IW'(dtry);
			end
			if (cmd.pick_cap) begin
				pick_q <= rd_q;
				ri_q   <= '0;
			end
			wr_s1 <= cmd.shift_step && shift_more;
			wa_s1 <= ri_q;
			if (cmd.shift_step && shift_more) ri_q <= ri_q + IW'(1);
			if (cmd.draw_end) begin
				wcnt_q <= wcnt_q - NW'(1);
				if (zdiff) begin
					zcnt_q <= zcnt_q - NW'(1);
				end else begin
					rv_q   <= 1'b1;
					rcol_q <= pick_q.col;
					rrow_q <= pick_q.row;
					rbel_q <= pick_q.below;
				end
			end
			if (cmd.next_cap) begin
				rv_q    <= 1'b1;
				rcol_q  <= rd_q.col;
				rrow_q  <= rd_q.row;
				rbel_q  <= rd_q.below;
				rlast_q <= last_nx;
				eptr_q  <= eptr_inc;
			end
			if (cmd.border_init) begin
				ba_q <= '0;
				bn_q <= '0;
			end
			if (cmd.border_step) begin
				ba_q <= ba_q + CW'(1);
				bn_q <= bn_q + BW'(rp) + BW'(bp);
				if (hit_r || hit_b) begin
					rv_q    <= 1'b1;
					rcol_q  <= hit_r ? gm1 : ba_q;
					rrow_q  <= hit_r ? ba_q : gm1;
					rbel_q  <= !hit_r;
					rlast_q <= last_nx;
					eptr_q  <= eptr_inc;
				end
			end
			if (cmd.out_load) begin
				out_valid  <= 1'b1;
				wall_valid <= rv_q;
				wall_col   <= rcol_q;
				wall_row   <= rrow_q;
				wall_below <= rbel_q;
				connected  <= (zcnt_q <= NW'(1));
				final_last <= rlast_q;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.op         = op_q;
		sts.fill_done  = fsub_q && (fx_q == gm1) && (fy_q == gm1);
		sts.div_last   = (dcnt_q == 4'd15);
		sts.draw_ok    = (zcnt_q > NW'(1)) && (wcnt_q != '0);
		sts.shift_done = !shift_more && !wr_s1;
		sts.next_ok    = (eptr_q < total);
		sts.next_tab   = (eptr_q < EW'(wcnt_q));
		sts.border_hit = hit_r || hit_b;
		sts.out_free   = !out_valid || !out_stall;
	end

	a_wcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= NW'(rstmg_pkg::WALL_DEPTH))
		else $error("wall count beyond table depth");
	a_zcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		zcnt_q <= NW'(rstmg_pkg::SIDE_MAX * rstmg_pkg::SIDE_MAX))
		else $error("zone count beyond cell count");
	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> (wa_s1 < IW'(wcnt_q)))
		else $error("shift write beyond live entries");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result loaded over a waiting result");

endmodule
`default_nettype wire

// ===== rtl/core/random_spanning_tree_maze_generator_unit.sv =====
`default_nettype none
// Channel | Handshake          | Payload
// input   | in_valid/in_stall  | operation, random_value, hole_col, hole_row
// output  | out_valid/out_stall| wall_valid, wall_col, wall_row, wall_below,
//         |                    | connected, final_last
// config  | cfg_we             | cfg_index, cfg_wdata
//
// Work from the accepting edge to the result register: start takes one table
// write slot per wall side of each cell; draw runs 16 remainder steps, then
// one pass over the wall table through its single read port; next reads the
// table or walks the border; a draw with nothing to do or an unused code goes
// straight to the result.
// Reset is asynchronous; no clearing pass, the table is bounded by its count.
// One item at a time; in_stall is high while an item is in work. A result
// waiting in the output register does not block taking the next item.
module random_spanning_tree_maze_generator_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [rstmg_pkg::SIDE_W-1:0] cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   operation,
	input  wire logic [rstmg_pkg::RND_W-1:0]  random_value,
	input  wire logic [rstmg_pkg::CRD_W-1:0]  hole_col,
	input  wire logic [rstmg_pkg::CRD_W-1:0]  hole_row,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              wall_valid,
	output logic [rstmg_pkg::CRD_W-1:0]       wall_col,
	output logic [rstmg_pkg::CRD_W-1:0]       wall_row,
	output logic                              wall_below,
	output logic                              connected,
	output logic                              final_last
);

	rstmg_pkg::cmd_t cmd;
	rstmg_pkg::sts_t sts;
	logic            busy;
	logic            in_accept;

	// item taken whenever the sequencer sits idle
	assign in_stall  = busy;
	assign in_accept = in_valid && !busy;

	rstmg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	rstmg_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_accept    (in_accept),
		.operation    (operation),
		.random_value (random_value),
		.hole_col     (hole_col),
		.hole_row     (hole_row),
		.cmd          (cmd),
		.sts          (sts),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.wall_valid   (wall_valid),
		.wall_col     (wall_col),
		.wall_row     (wall_row),
		.wall_below   (wall_below),
		.connected    (connected),
		.final_last   (final_last)
	);

endmodule
`default_nettype wire

// ===== tb/sv/random_spanning_tree_maze_generator_unit_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
// Maze generator regression.
// An initial block runs phases: it writes side_size and border_mode while the
// block is idle, then queues a start, a run of draws and a run of next items.
// A clocked driver feeds the queue with random gaps; a clocked monitor
// checks every result against a built-in copy of the Kruskal wall table.
module random_spanning_tree_maze_generator_unit_test;
	import rstmg_pkg::*;

	localparam logic [1:0] OP_NOP = 2'd3;   // unused code, must act as a no-op

	typedef struct {
		logic [1:0]  op;
		logic [15:0] rnd;
		logic [3:0]  hc;
		logic [3:0]  hr;
	} maze_item_t;

	typedef struct {
		logic       wv;
		logic [3:0] col;
		logic [3:0] row;
		logic       below;
		logic       conn;
		logic       last;
	} wall_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [SIDE_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] operation = OP_START;
	logic [RND_W-1:0] random_value = '0;
	logic [CRD_W-1:0] hole_col = '0;
	logic [CRD_W-1:0] hole_row = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic wall_valid, wall_below, connected, final_last;
	logic [CRD_W-1:0] wall_col, wall_row;

	random_spanning_tree_maze_generator_unit uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---- predicted state of the block ----
	int zone_a [WALL_DEPTH];
	int zone_b [WALL_DEPTH];
	logic [3:0] w_col [WALL_DEPTH];
	logic [3:0] w_row [WALL_DEPTH];
	logic w_below [WALL_DEPTH];
	int walls_left = 0;
	int zones_left = 0;
	int emit_ptr = 0;
	logic [3:0] hole_r_border = '0;  // row open in the right border
	logic [3:0] hole_b_border = '0;  // column open in the bottom border
	logic [4:0] side_reg = 5'd8;
	logic [1:0] border_reg = 2'd0;
	int grid = 2;

	maze_item_t pending_items[$];
	wall_res_t expected_walls[$];
	int errors = 0;
	bit calm = 0;      // phase without any idling
	bit took = 0;

	// walk border walls; returns total, fills entry k when present
	function automatic int border_walk(input int k, output logic [3:0] c,
			output logic [3:0] r, output logic b);
		int n;
		n = 0;
		c = '0;
		r = '0;
		b = 1'b0;
		if (border_reg == 0)
			return 0;
		for (int a = 0; a < grid; a++) begin
			if (border_reg[0] && a != hole_r_border) begin
				if (n == k) begin
					c = 4'(grid - 1);
					r = 4'(a);
					b = 1'b0;
				end
				n++;
			end
			if (border_reg > 1 && a != hole_b_border) begin
				if (n == k) begin
					c = 4'(a);
					r = 4'(grid - 1);
					b = 1'b1;
				end
				n++;
			end
		end
		return n;
	endfunction

	task automatic add_wall(input int za, input int zb, input int x, input int y,
			input logic b);
		zone_a[walls_left] = za;
		zone_b[walls_left] = zb;
		w_col[walls_left] = 4'(x);
		w_row[walls_left] = 4'(y);
		w_below[walls_left] = b;
		walls_left++;
	endtask

	task automatic predict_maze_step(input maze_item_t it);
		wall_res_t res;
		int idx, za, zb, nb;
		logic [3:0] c, r;
		logic b;
		res = '{1'b0, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0};
		case (it.op)
			OP_START: begin
				grid = side_reg < 2 ? 2 : (side_reg > SIDE_MAX ? SIDE_MAX : int'(side_reg));
				walls_left = 0;
				for (int y = 0; y < grid; y++)
					for (int x = 0; x < grid; x++) begin
						if (x != grid - 1)
							add_wall(y * grid + x, y * grid + x + 1, x, y, 1'b0);
						if (y != grid - 1)
							add_wall(y * grid + x, y * grid + x + grid, x, y, 1'b1);
					end
				zones_left = grid * grid;
				emit_ptr = 0;
				hole_r_border = it.hc;
				hole_b_border = it.hr;
			end
			OP_DRAW: begin
				if (zones_left > 1 && walls_left != 0) begin
					idx = int'(it.rnd) % walls_left;
					za = zone_a[idx];
					zb = zone_b[idx];
					c = w_col[idx];
					r = w_row[idx];
					b = w_below[idx];
					for (int i = idx; i + 1 < walls_left; i++) begin
						zone_a[i] = zone_a[i + 1];
						zone_b[i] = zone_b[i + 1];
						w_col[i] = w_col[i + 1];
						w_row[i] = w_row[i + 1];
						w_below[i] = w_below[i + 1];
					end
					walls_left--;
					if (za != zb) begin
						// merge: relabel the second zone everywhere
						for (int i = 0; i < walls_left; i++) begin
							if (zone_a[i] == zb) zone_a[i] = za;
							if (zone_b[i] == zb) zone_b[i] = za;
						end
						zones_left--;
					end else begin
						res.wv = 1'b1;
						res.col = c;
						res.row = r;
						res.below = b;
					end
				end
			end
			OP_NEXT: begin
				nb = border_walk(-1, c, r, b);
				if (emit_ptr < walls_left + nb) begin
					if (emit_ptr < walls_left) begin
						c = w_col[emit_ptr];
						r = w_row[emit_ptr];
						b = w_below[emit_ptr];
					end else
						void'(border_walk(emit_ptr - walls_left, c, r, b));
					res.wv = 1'b1;
					res.col = c;
					res.row = r;
					res.below = b;
					res.last = (emit_ptr + 1 == walls_left + nb);
					emit_ptr = (emit_ptr + 1) % 1024;
				end
			end
			default: ;
		endcase
		res.conn = (zones_left <= 1);
		expected_walls.push_back(res);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int gap_len();
		int p;
		if (calm)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ---- driver: accept at posedge, change inputs at negedge ----
	int in_gap = 0;
	int st_gap = 0;

	always @(posedge clk) begin
		took <= in_valid && !in_stall;
		if (in_valid && !in_stall)
			predict_maze_step('{operation, random_value, hole_col, hole_row});
	end

	always @(negedge clk) begin
		maze_item_t it;
		if (arst_n) begin
			if (in_valid && !took) begin
				// stalled: hold the item
			end else if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				operation <= it.op;
				random_value <= it.rnd;
				hole_col <= it.hc;
				hole_row <= it.hr;
				in_valid <= 1'b1;
				in_gap = gap_len();
			end else
				in_valid <= 1'b0;
			// receiver stall pattern
			if (st_gap > 0) begin
				st_gap--;
				out_stall <= 1'b1;
			end else begin
				st_gap = gap_len();
				out_stall <= 1'b0;
			end
		end
	end

	// ---- monitor ----
	always @(posedge clk) begin
		wall_res_t w;
		if (out_valid && !out_stall) begin
			if (expected_walls.size() == 0) begin
				report_mismatch("unexpected item", 1, 0);
			end else begin
				w = expected_walls.pop_front();
				if (wall_valid !== w.wv) report_mismatch("wall_valid", wall_valid, w.wv);
				if (wall_col !== w.col) report_mismatch("wall_col", wall_col, w.col);
				if (wall_row !== w.row) report_mismatch("wall_row", wall_row, w.row);
				if (wall_below !== w.below) report_mismatch("wall_below", wall_below, w.below);
				if (connected !== w.conn) report_mismatch("connected", connected, w.conn);
				if (final_last !== w.last) report_mismatch("final_last", final_last, w.last);
			end
		end
	end

	// ---- stimulus ----
	task automatic queue_op(input logic [1:0] op, input int rnd = -1,
			input int hc = -1, input int hr = -1);
		maze_item_t it;
		it.op = op;
		it.rnd = rnd < 0 ? 16'($urandom_range(0, 65535)) : 16'(rnd);
		it.hc = hc < 0 ? 4'($urandom_range(0, 15)) : 4'(hc);
		it.hr = hr < 0 ? 4'($urandom_range(0, 15)) : 4'(hr);
		pending_items.push_back(it);
	endtask

	task automatic write_reg(input logic idx, input logic [4:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_SIDE)
			side_reg = val;
		else
			border_reg = val[1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// drain everything; results are one per item so the block is then idle
	task automatic drain();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || in_valid || expected_walls.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// well-formed maze: start, draws until a tree with some next and no-op items mixed in, then the full emit run
	task automatic queue_maze(input int s, input int extra_noise);
		int nd;
		queue_op(OP_START);
		nd = 3 * s * s;
		for (int i = 0; i < nd; i++) begin
			if ($urandom_range(0, 99) < extra_noise)
				queue_op($urandom_range(0, 1) ? OP_NEXT : OP_NOP);
			queue_op(OP_DRAW);
		end
		for (int i = 0; i < 2 * s * s + 2 * s + 3; i++)
			queue_op(OP_NEXT);
	endtask

	int sent;
	int s;

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: before any start, no-op code, holes, value extremes
		calm = 1;
		write_reg(REG_BORDER, 5'd3);
		queue_op(OP_DRAW, 16'hFFFF);
		queue_op(OP_NEXT);
		queue_op(OP_NOP);
		queue_op(OP_START, 0, 0, 15);   // side 8 from reset; bottom hole beyond
		queue_op(OP_NEXT);              // emit before connected
		queue_op(OP_NEXT);
		queue_op(OP_DRAW, 16'hFFFF);    // draw in the middle of a next run
		queue_op(OP_DRAW, 0);
		queue_op(OP_NEXT);
		drain();
		write_reg(REG_SIDE, 5'd0);      // clamps to 2
		queue_op(OP_START, 0, 1, 1);
		repeat (4) queue_op(OP_DRAW, 0);    // last ones hit connected
		repeat (7) queue_op(OP_NEXT);       // runs past the end
		drain();
		write_reg(REG_SIDE, 5'd31);     // clamps to the maximum
		write_reg(REG_BORDER, 5'd1);
		queue_op(OP_START, 0, 15, 0);
		queue_op(OP_DRAW, 16'hFFFF);
		queue_op(OP_DRAW, 0);
		queue_op(OP_NEXT);
		drain();
		write_reg(REG_SIDE, 5'd16);
		write_reg(REG_BORDER, 5'd2);
		queue_op(OP_START, 65535, 3, 8);
		queue_op(OP_DRAW, 16'h5555);
		queue_op(OP_NEXT);
		drain();

		// random phases
		sent = 0;
		while (sent < 1000) begin
			calm = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 19))
				0: s = $urandom_range(0, 1);
				1: s = $urandom_range(17, 31);
				2: s = $urandom_range(7, 9);
				default: s = $urandom_range(2, 5);
			endcase
			write_reg(REG_SIDE, 5'(s));
			write_reg(REG_BORDER, 5'($urandom_range(0, 3)));
			s = s < 2 ? 2 : (s > SIDE_MAX ? SIDE_MAX : s);
			if (s > 9) begin
				// big grids only get a short broken sequence
				queue_op(OP_START);
				repeat (5) queue_op($urandom_range(0, 3) ? OP_DRAW : OP_NEXT);
			end else if ($urandom_range(0, 5) == 0) begin
				repeat (20) queue_op(2'($urandom_range(0, 3)));
			end else
				queue_maze(s, 8);
			sent += pending_items.size();
			drain();
		end

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#50ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
